FILE: rtl/core/aro_pkg.sv
// ----------------------------------------------------------------------------
// aro_pkg
// Shared types and constants of the annealing route optimizer.
// ----------------------------------------------------------------------------
`default_nettype none

package aro_pkg;

	localparam int MAX_CITIES_DEF = 64;
	localparam int DIST_BITS_DEF  = 16;

	localparam int OPCODE_W   = 3;
	localparam int INDEX_A_W  = 7;
	localparam int INDEX_B_W  = 6;
	localparam int LOAD_W     = 16;
	localparam int DRAW_W     = 10;
	localparam int COST_OUT_W = 22;
	localparam int CITY_OUT_W = 6;
	localparam int STALL_W    = 16;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 72;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int COUNT_W     = 7;
	localparam int TEMP_W      = 32;
	localparam int COOL_W      = 16;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd48;
	localparam logic [TEMP_W-1:0]  TEMP_RESET  = 32'd262144000;
	localparam logic [COOL_W-1:0]  COOL_RESET  = 16'd64881;
	localparam logic [STALL_W-1:0] STALL_RESET = 16'd500;

	localparam int MIN_COUNT  = 3;
	localparam int DRAW_SCALE = 1000;
	localparam int LN2_Q16    = 45426;
	localparam int DELTA_BITS = 20;
	localparam int MUL_W      = 32;
	localparam int LOG_Y_W    = 31;
	localparam int LOG_R_W    = 20;
	localparam int LOG_FRAC   = 16;

	typedef enum logic [OPCODE_W-1:0] {
		OP_LOAD_DIST  = 3'd0,
		OP_LOAD_ROUTE = 3'd1,
		OP_REVERSE    = 3'd2,
		OP_SWAP       = 3'd3,
		OP_INSERT     = 3'd4,
		OP_READ_BEST  = 3'd5,
		OP_START      = 3'd6,
		OP_NOP        = 3'd7
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_CITY_COUNT  = 2'd0,
		CFG_START_TEMP  = 2'd1,
		CFG_COOLING     = 2'd2,
		CFG_STALL_LIMIT = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MAP_IDENT,
		MAP_REVERSE,
		MAP_SWAP,
		MAP_INSERT
	} map_t;

	typedef enum logic [1:0] {
		SRC_CUR,
		SRC_CAND,
		SRC_BEST
	} src_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_MOD_MUL,
		ST_MOD_WR,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_SWEEP,
		ST_START_DONE,
		ST_CAND_DONE,
		ST_LOG_INIT,
		ST_LOG_MUL,
		ST_LOG_UPD,
		ST_LN_MUL,
		ST_TL_MUL,
		ST_TL_CMP,
		ST_APPLY,
		ST_COOL_MUL,
		ST_COOL_WR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic go;
		map_t mode;
	} sweep_cmd_t;

	typedef struct packed {
		logic valid;
		logic pair;
		logic last;
	} sweep_stat_t;

	typedef struct packed {
		src_t   src;
		logic   dst_cur;
		logic   dst_cand;
		logic   dst_best;
		logic   cost;
		state_t after;
	} sweep_plan_t;

endpackage

`default_nettype wire

FILE: rtl/core/aro_ram.sv
// ----------------------------------------------------------------------------
// aro_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aro_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/core/aro_mul.sv
// ----------------------------------------------------------------------------
// aro_mul
// Shared 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module aro_mul (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [aro_pkg::MUL_W-1:0]     op_a,
	input  wire logic [aro_pkg::MUL_W-1:0]     op_b,
	output logic      [2*aro_pkg::MUL_W-1:0]   prod
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod <= op_a * op_b;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/aro_sweep.sv
// ----------------------------------------------------------------------------
// aro_sweep
// Slot walker for route copies: steps every slot once and maps each
// destination slot to its source slot under the selected move.
// ----------------------------------------------------------------------------
`default_nettype none

module aro_sweep #(
	parameter int MAX_CITIES = aro_pkg::MAX_CITIES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire aro_pkg::sweep_cmd_t               cmd,
	input  wire logic [$clog2(MAX_CITIES+1)-1:0]   pos_a,
	input  wire logic [$clog2(MAX_CITIES+1)-1:0]   pos_b,
	input  wire logic [$clog2(MAX_CITIES+1)-1:0]   count,
	output logic      [$clog2(MAX_CITIES+1)-1:0]   rd_addr,
	output logic      [$clog2(MAX_CITIES+1)-1:0]   slot_s1,
	output aro_pkg::sweep_stat_t                   stat_s1,
	output logic                                   busy
);

	localparam int RA_W = $clog2(MAX_CITIES+1);
	localparam logic [RA_W-1:0] LAST_SLOT = RA_W'(MAX_CITIES);

	logic              busy_q;
	logic [RA_W-1:0]   idx_q;
	aro_pkg::map_t     mode_q;
	logic [RA_W-1:0]   lo;
	logic [RA_W-1:0]   hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			mode_q  <= aro_pkg::MAP_IDENT;
			stat_s1 <= '0;
		end else begin
			if (cmd.go) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				mode_q <= cmd.mode;
			end else if (busy_q) begin
				if (idx_q == LAST_SLOT) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			stat_s1.valid <= busy_q;
			stat_s1.pair  <= busy_q && (idx_q != '0) && (idx_q <= count);
			stat_s1.last  <= busy_q && (idx_q == LAST_SLOT);
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= idx_q;
	end

	assign busy = busy_q;
	assign lo   = (pos_a < pos_b) ? pos_a : pos_b;
	assign hi   = (pos_a < pos_b) ? pos_b : pos_a;

	always_comb begin
		rd_addr = idx_q;
		case (mode_q)
			aro_pkg::MAP_REVERSE: begin
				if (idx_q >= lo && idx_q <= hi) begin
					rd_addr = RA_W'({1'b0, lo} + {1'b0, hi} - {1'b0, idx_q});
				end
			end
			aro_pkg::MAP_SWAP: begin
				if (idx_q == pos_a) begin
					rd_addr = pos_b;
				end else if (idx_q == pos_b) begin
					rd_addr = pos_a;
				end
			end
			aro_pkg::MAP_INSERT: begin
				if (idx_q == pos_b) begin
					rd_addr = pos_a;
				end else if (pos_a < pos_b) begin
					if (idx_q >= pos_a && idx_q < pos_b) begin
						rd_addr = idx_q + 1'b1;
					end
				end else begin
					if (idx_q > pos_b && idx_q <= pos_a) begin
						rd_addr = idx_q - 1'b1;
					end
				end
			end
			default: begin
				rd_addr = idx_q;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/annealing_route_optimizer_top.sv
// ----------------------------------------------------------------------------
// annealing_route_optimizer_top
// Simulated annealing engine for a closed tour: route memories, distance
// memory, slot walker, shared multiplier and the sequencer around them.
// ----------------------------------------------------------------------------
//   channel   direction  handshake           payload
//   s_*       in         s_tvalid/s_tready   s_tdata: command item
//   m_*       out        m_tvalid/m_tready   m_tdata: result item
//   cfg_*     in         cfg_we              cfg_index, cfg_data
//
// one item at a time; s_tready is high only while the sequencer is idle
// a start walks the route slots once, and a move walks them once for the
// candidate and again when the route is copied back, with the log unit run
// in between when the acceptance test needs the log; the one multiplier
// serves the route-load modulo, log squaring, the ln2 scaling, the test
// product and cooling
// a finished result waits in the output register while m_tready is low, and
// the next result holds the sequencer until that register is free
// reset clears control state and totals; memories hold garbage until loaded
// ----------------------------------------------------------------------------
`default_nettype none

module annealing_route_optimizer_top #(
	parameter int MAX_CITIES = aro_pkg::MAX_CITIES_DEF,
	parameter int DIST_BITS  = aro_pkg::DIST_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// opcode, index_a, index_b, load_value, random_draw
	input  wire logic [aro_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// status, accepted, restarted, current_cost, best_cost, city_out, stall_count
	output logic      [aro_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  wire logic                               cfg_we,
	input  wire logic [aro_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [aro_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CITY_W      = $clog2(MAX_CITIES);
	localparam int RA_W        = $clog2(MAX_CITIES+1);
	localparam int ROUTE_DEPTH = MAX_CITIES + 1;
	localparam int DIST_DEPTH  = MAX_CITIES * MAX_CITIES;
	localparam int DADDR_W     = $clog2(DIST_DEPTH);
	localparam int COST_W      = DIST_BITS + $clog2(MAX_CITIES+1);
	localparam int MW          = aro_pkg::MUL_W;
	localparam logic [MW-1:0] RECIP = MW'(64'h1_0000_0000 / MAX_CITIES);

	// item fields
	aro_pkg::op_t                    op_q;
	logic [aro_pkg::INDEX_A_W-1:0]   a_q;
	logic [aro_pkg::INDEX_B_W-1:0]   b_q;
	logic [aro_pkg::LOAD_W-1:0]      val_q;
	logic [aro_pkg::DRAW_W-1:0]      draw_q;

	// config
	logic [aro_pkg::COUNT_W-1:0]     city_count_q;
	logic [aro_pkg::TEMP_W-1:0]      start_temp_q;
	logic [aro_pkg::COOL_W-1:0]      cool_q;
	logic [aro_pkg::STALL_W-1:0]     stall_lim_q;

	// annealing state
	logic [COST_W-1:0]               cur_total_q;
	logic [COST_W-1:0]               best_total_q;
	logic [aro_pkg::TEMP_W-1:0]      temp_q;
	logic [aro_pkg::STALL_W-1:0]     run_q;
	logic [COST_W-1:0]               acc_q;
	logic                            take_q;

	// result flags
	logic                            status_q;
	logic                            acc_flag_q;
	logic                            rst_flag_q;
	logic [CITY_W-1:0]               city_q;
	logic                            m_tvalid_q;
	logic [aro_pkg::OUT_DATA_W-1:0]  m_tdata_q;

	// log unit
	logic [aro_pkg::LOG_Y_W-1:0]     y_q;
	logic [aro_pkg::LOG_R_W-1:0]     lr_q;
	logic [aro_pkg::LOG_R_W-1:0]     l1000_q;
	logic [3:0]                      bit_q;
	logic                            log_sel_q;

	aro_pkg::state_t                 state_q;
	aro_pkg::state_t                 state_d;
	aro_pkg::state_t                 after_q;

	// sweep
	aro_pkg::sweep_cmd_t             sweep_cmd;
	aro_pkg::sweep_plan_t            plan;
	aro_pkg::sweep_stat_t            stat_s1;
	aro_pkg::src_t                   src_q;
	logic                            dst_cur_q;
	logic                            dst_cand_q;
	logic                            dst_best_q;
	logic                            cost_q;
	logic                            pair_s2;
	logic                            last_s2;
	logic [RA_W-1:0]                 sw_rd_addr;
	logic [RA_W-1:0]                 slot_s1;
	logic                            sweep_busy;
	logic [RA_W-1:0]                 n_slots;
	logic [CITY_W-1:0]               prev_q;

	// memories
	logic                            cur_we;
	logic [RA_W-1:0]                 cur_waddr;
	logic [CITY_W-1:0]               cur_wdata;
	logic [CITY_W-1:0]               cur_rdata;
	logic [CITY_W-1:0]               cand_rdata;
	logic [RA_W-1:0]                 best_raddr;
	logic [CITY_W-1:0]               best_rdata;
	logic [CITY_W-1:0]               src_data;
	logic                            dist_we;
	logic [DADDR_W-1:0]              dist_waddr;
	logic [DADDR_W-1:0]              dist_raddr;
	logic [DIST_BITS-1:0]            dist_rdata;

	// multiplier
	logic                            mul_en;
	logic [MW-1:0]                   mul_a;
	logic [MW-1:0]                   mul_b;
	logic [2*MW-1:0]                 mul_prod;

	// misc datapath
	logic                            accept_in;
	logic                            move_bad;
	logic [31:0]                     rem_w;
	logic [CITY_W-1:0]               city_ld;
	logic [aro_pkg::DRAW_W-1:0]      log_v;
	logic [3:0]                      log_ip;
	logic [aro_pkg::LOG_Y_W-1:0]     y_init;
	logic [MW-1:0]                   sq_w;
	logic [aro_pkg::LOG_Y_W-1:0]     y_next;
	logic [aro_pkg::LOG_R_W-1:0]     lr_next;
	logic [63:0]                     delta_w;
	logic                            delta_big;
	logic                            cand_lt;
	logic [aro_pkg::STALL_W-1:0]     run_inc;
	logic [aro_pkg::STALL_W-1:0]     lim;
	logic                            restart;

	assign s_tready  = (state_q == aro_pkg::ST_IDLE);
	assign accept_in = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// ---------------------------------------------------------------- units
	aro_sweep #(.MAX_CITIES(MAX_CITIES)) u_sweep (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (sweep_cmd),
		.pos_a   (RA_W'(a_q)),
		.pos_b   (RA_W'(b_q)),
		.count   (n_slots),
		.rd_addr (sw_rd_addr),
		.slot_s1 (slot_s1),
		.stat_s1 (stat_s1),
		.busy    (sweep_busy)
	);

	aro_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (mul_prod)
	);

	aro_ram #(.WIDTH(CITY_W), .DEPTH(ROUTE_DEPTH)) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (cur_waddr),
		.wdata (cur_wdata),
		.raddr (sw_rd_addr),
		.rdata (cur_rdata)
	);

	aro_ram #(.WIDTH(CITY_W), .DEPTH(ROUTE_DEPTH)) u_cand_ram (
		.clk   (clk),
		.we    (stat_s1.valid && dst_cand_q),
		.waddr (slot_s1),
		.wdata (src_data),
		.raddr (sw_rd_addr),
		.rdata (cand_rdata)
	);

	aro_ram #(.WIDTH(CITY_W), .DEPTH(ROUTE_DEPTH)) u_best_ram (
		.clk   (clk),
		.we    (stat_s1.valid && dst_best_q),
		.waddr (slot_s1),
		.wdata (src_data),
		.raddr (best_raddr),
		.rdata (best_rdata)
	);

	aro_ram #(.WIDTH(DIST_BITS), .DEPTH(DIST_DEPTH)) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (DIST_BITS'(val_q)),
		.raddr (dist_raddr),
		.rdata (dist_rdata)
	);

	// ------------------------------------------------------------- datapath
	always_comb begin
		if (int'(city_count_q) < aro_pkg::MIN_COUNT) begin
			n_slots = RA_W'(aro_pkg::MIN_COUNT);
		end else if (int'(city_count_q) > MAX_CITIES) begin
			n_slots = RA_W'(MAX_CITIES);
		end else begin
			n_slots = RA_W'(city_count_q);
		end
	end

	assign move_bad = (int'(a_q) == int'(b_q)) || (a_q == '0) || (b_q == '0) ||
		(int'(a_q) > int'(n_slots) - 1) || (int'(b_q) > int'(n_slots) - 1);

	always_comb begin
		case (src_q)
			aro_pkg::SRC_CAND: src_data = cand_rdata;
			aro_pkg::SRC_BEST: src_data = best_rdata;
			default:           src_data = cur_rdata;
		endcase
	end

	assign dist_raddr = DADDR_W'(prev_q) * DADDR_W'(MAX_CITIES) + DADDR_W'(src_data);
	assign dist_waddr = DADDR_W'(a_q) * DADDR_W'(MAX_CITIES) + DADDR_W'(b_q);
	assign best_raddr = (state_q == aro_pkg::ST_RD_ADDR) ? RA_W'(a_q) : sw_rd_addr;

	// city number modulo the table size via reciprocal
	assign rem_w   = 32'(val_q) - mul_prod[2*MW-1:MW] * 32'(MAX_CITIES);
	assign city_ld = (rem_w >= 32'(MAX_CITIES)) ? CITY_W'(rem_w - 32'(MAX_CITIES))
		: CITY_W'(rem_w);

	assign cur_we    = (stat_s1.valid && dst_cur_q) || (state_q == aro_pkg::ST_MOD_WR);
	assign cur_waddr = (state_q == aro_pkg::ST_MOD_WR) ? RA_W'(a_q) : slot_s1;
	assign cur_wdata = (state_q == aro_pkg::ST_MOD_WR) ? city_ld : src_data;

	// log2 in q16 by repeated squaring
	assign log_v = log_sel_q ? draw_q : aro_pkg::DRAW_W'(aro_pkg::DRAW_SCALE);

	always_comb begin
		log_ip = '0;
		for (int i = 0; i < aro_pkg::DRAW_W; i++) begin
			if (log_v[i]) begin
				log_ip = 4'(i);
			end
		end
	end

	assign y_init = aro_pkg::LOG_Y_W'(log_v) << (5'd30 - 5'(log_ip));
	assign sq_w   = mul_prod[61:30];
	assign y_next = sq_w[MW-1] ? sq_w[MW-1:1] : sq_w[aro_pkg::LOG_Y_W-1:0];
	assign lr_next = sq_w[MW-1] ? (lr_q | (aro_pkg::LOG_R_W'(1) << bit_q)) : lr_q;

	assign cand_lt   = acc_q < cur_total_q;
	assign delta_w   = 64'(acc_q) - 64'(cur_total_q);
	assign delta_big = |delta_w[63:aro_pkg::DELTA_BITS];
	assign run_inc   = run_q + 1'b1;
	assign lim       = (stall_lim_q == '0) ? aro_pkg::STALL_W'(1) : stall_lim_q;
	assign restart   = run_inc >= lim;

	// ------------------------------------------------------------ sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aro_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		mul_en         = 1'b0;
		mul_a          = '0;
		mul_b          = '0;
		dist_we        = 1'b0;
		sweep_cmd.go   = 1'b0;
		sweep_cmd.mode = aro_pkg::MAP_IDENT;
		plan.src       = aro_pkg::SRC_CUR;
		plan.dst_cur   = 1'b0;
		plan.dst_cand  = 1'b0;
		plan.dst_best  = 1'b0;
		plan.cost      = 1'b0;
		plan.after     = aro_pkg::ST_FINISH;
		case (state_q)
			aro_pkg::ST_IDLE: begin
				if (accept_in) begin
					state_d = aro_pkg::ST_DISPATCH;
				end
			end
			aro_pkg::ST_DISPATCH: begin
				state_d = aro_pkg::ST_FINISH;
				case (op_q)
					aro_pkg::OP_LOAD_DIST: begin
						dist_we = (int'(a_q) < MAX_CITIES) && (int'(b_q) < MAX_CITIES);
					end
					aro_pkg::OP_LOAD_ROUTE: begin
						if (int'(a_q) <= MAX_CITIES) begin
							state_d = aro_pkg::ST_MOD_MUL;
						end
					end
					aro_pkg::OP_REVERSE, aro_pkg::OP_SWAP, aro_pkg::OP_INSERT: begin
						if (!move_bad) begin
							sweep_cmd.go  = 1'b1;
							plan.dst_cand = 1'b1;
							plan.cost     = 1'b1;
							plan.after    = aro_pkg::ST_CAND_DONE;
							state_d       = aro_pkg::ST_SWEEP;
							case (op_q)
								aro_pkg::OP_REVERSE: sweep_cmd.mode = aro_pkg::MAP_REVERSE;
								aro_pkg::OP_SWAP:    sweep_cmd.mode = aro_pkg::MAP_SWAP;
								default:             sweep_cmd.mode = aro_pkg::MAP_INSERT;
							endcase
						end
					end
					aro_pkg::OP_READ_BEST: begin
						if (int'(a_q) <= MAX_CITIES) begin
							state_d = aro_pkg::ST_RD_ADDR;
						end
					end
					aro_pkg::OP_START: begin
						sweep_cmd.go  = 1'b1;
						plan.dst_best = 1'b1;
						plan.cost     = 1'b1;
						plan.after    = aro_pkg::ST_START_DONE;
						state_d       = aro_pkg::ST_SWEEP;
					end
					default: begin
						state_d = aro_pkg::ST_FINISH;
					end
				endcase
			end
			aro_pkg::ST_MOD_MUL: begin
				mul_en  = 1'b1;
				mul_a   = MW'(val_q);
				mul_b   = RECIP;
				state_d = aro_pkg::ST_MOD_WR;
			end
			aro_pkg::ST_MOD_WR: begin
				state_d = aro_pkg::ST_FINISH;
			end
			aro_pkg::ST_RD_ADDR: begin
				state_d = aro_pkg::ST_RD_DATA;
			end
			aro_pkg::ST_RD_DATA: begin
				state_d = aro_pkg::ST_FINISH;
			end
			aro_pkg::ST_SWEEP: begin
				if (last_s2) begin
					state_d = after_q;
				end
			end
			aro_pkg::ST_START_DONE: begin
				state_d = aro_pkg::ST_FINISH;
			end
			aro_pkg::ST_CAND_DONE: begin
				if (cand_lt || draw_q == '0) begin
					state_d = aro_pkg::ST_APPLY;
				end else if (int'(draw_q) >= aro_pkg::DRAW_SCALE || delta_big) begin
					state_d = aro_pkg::ST_APPLY;
				end else begin
					state_d = aro_pkg::ST_LOG_INIT;
				end
			end
			aro_pkg::ST_LOG_INIT: begin
				state_d = aro_pkg::ST_LOG_MUL;
			end
			aro_pkg::ST_LOG_MUL: begin
				mul_en  = 1'b1;
				mul_a   = MW'(y_q);
				mul_b   = MW'(y_q);
				state_d = aro_pkg::ST_LOG_UPD;
			end
			aro_pkg::ST_LOG_UPD: begin
				if (bit_q != '0) begin
					state_d = aro_pkg::ST_LOG_MUL;
				end else if (!log_sel_q) begin
					state_d = aro_pkg::ST_LOG_INIT;
				end else begin
					state_d = aro_pkg::ST_LN_MUL;
				end
			end
			aro_pkg::ST_LN_MUL: begin
				mul_en  = 1'b1;
				mul_a   = MW'(l1000_q) - MW'(lr_q);
				mul_b   = MW'(aro_pkg::LN2_Q16);
				state_d = aro_pkg::ST_TL_MUL;
			end
			aro_pkg::ST_TL_MUL: begin
				mul_en  = 1'b1;
				mul_a   = temp_q;
				mul_b   = mul_prod[47:16];
				state_d = aro_pkg::ST_TL_CMP;
			end
			aro_pkg::ST_TL_CMP: begin
				state_d = aro_pkg::ST_APPLY;
			end
			aro_pkg::ST_APPLY: begin
				state_d    = aro_pkg::ST_COOL_MUL;
				plan.after = aro_pkg::ST_COOL_MUL;
				if (take_q) begin
					sweep_cmd.go  = 1'b1;
					plan.src      = aro_pkg::SRC_CAND;
					plan.dst_cur  = 1'b1;
					plan.dst_best = acc_q < best_total_q;
					state_d       = aro_pkg::ST_SWEEP;
				end else if (restart) begin
					sweep_cmd.go = 1'b1;
					plan.src     = aro_pkg::SRC_BEST;
					plan.dst_cur = 1'b1;
					state_d      = aro_pkg::ST_SWEEP;
				end
			end
			aro_pkg::ST_COOL_MUL: begin
				mul_en  = 1'b1;
				mul_a   = temp_q;
				mul_b   = MW'(cool_q);
				state_d = aro_pkg::ST_COOL_WR;
			end
			aro_pkg::ST_COOL_WR: begin
				state_d = aro_pkg::ST_FINISH;
			end
			aro_pkg::ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = aro_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = aro_pkg::ST_IDLE;
			end
		endcase
	end

	// control state and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			city_count_q <= aro_pkg::COUNT_RESET;
			start_temp_q <= aro_pkg::TEMP_RESET;
			cool_q       <= aro_pkg::COOL_RESET;
			stall_lim_q  <= aro_pkg::STALL_RESET;
			cur_total_q  <= '0;
			best_total_q <= '0;
			temp_q       <= '0;
			run_q        <= '0;
			m_tvalid_q   <= 1'b0;
			src_q        <= aro_pkg::SRC_CUR;
			dst_cur_q    <= 1'b0;
			dst_cand_q   <= 1'b0;
			dst_best_q   <= 1'b0;
			cost_q       <= 1'b0;
			after_q      <= aro_pkg::ST_FINISH;
			pair_s2      <= 1'b0;
			last_s2      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (aro_pkg::cfg_idx_t'(cfg_index))
					aro_pkg::CFG_CITY_COUNT:  city_count_q <= aro_pkg::COUNT_W'(cfg_data);
					aro_pkg::CFG_START_TEMP:  start_temp_q <= cfg_data;
					aro_pkg::CFG_COOLING:     cool_q <= aro_pkg::COOL_W'(cfg_data);
					aro_pkg::CFG_STALL_LIMIT: stall_lim_q <= aro_pkg::STALL_W'(cfg_data);
					default: begin
					end
				endcase
			end

			if (sweep_cmd.go) begin
				src_q      <= plan.src;
				dst_cur_q  <= plan.dst_cur;
				dst_cand_q <= plan.dst_cand;
				dst_best_q <= plan.dst_best;
				cost_q     <= plan.cost;
				after_q    <= plan.after;
			end
			pair_s2 <= stat_s1.pair && cost_q;
			last_s2 <= stat_s1.last;

			case (state_q)
				aro_pkg::ST_START_DONE: begin
					cur_total_q  <= acc_q;
					best_total_q <= acc_q;
					temp_q       <= start_temp_q;
					run_q        <= '0;
				end
				aro_pkg::ST_APPLY: begin
					if (take_q) begin
						run_q       <= '0;
						cur_total_q <= acc_q;
						if (acc_q < best_total_q) begin
							best_total_q <= acc_q;
						end
					end else if (restart) begin
						run_q       <= '0;
						cur_total_q <= best_total_q;
					end else begin
						run_q <= run_inc;
					end
				end
				aro_pkg::ST_COOL_WR: begin
					temp_q <= mul_prod[47:16];
				end
				default: begin
				end
			endcase

			if (state_q == aro_pkg::ST_FINISH && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept_in) begin
			op_q       <= aro_pkg::op_t'(s_tdata[2:0]);
			a_q        <= s_tdata[9:3];
			b_q        <= s_tdata[15:10];
			val_q      <= s_tdata[31:16];
			draw_q     <= s_tdata[41:32];
			status_q   <= 1'b0;
			acc_flag_q <= 1'b0;
			rst_flag_q <= 1'b0;
			city_q     <= '0;
			take_q     <= 1'b0;
			log_sel_q  <= 1'b0;
		end

		if (sweep_cmd.go && plan.cost) begin
			acc_q <= '0;
		end else if (pair_s2) begin
			acc_q <= acc_q + COST_W'(dist_rdata);
		end
		if (stat_s1.valid) begin
			prev_q <= src_data;
		end

		case (state_q)
			aro_pkg::ST_DISPATCH: begin
				if ((op_q == aro_pkg::OP_REVERSE || op_q == aro_pkg::OP_SWAP ||
					op_q == aro_pkg::OP_INSERT) && move_bad) begin
					status_q <= 1'b1;
				end
			end
			aro_pkg::ST_RD_DATA: begin
				city_q <= best_rdata;
			end
			aro_pkg::ST_CAND_DONE: begin
				take_q <= cand_lt || (draw_q == '0);
			end
			aro_pkg::ST_LOG_INIT: begin
				y_q   <= y_init;
				lr_q  <= {log_ip, aro_pkg::LOG_FRAC'(0)};
				bit_q <= 4'd15;
			end
			aro_pkg::ST_LOG_UPD: begin
				y_q   <= y_next;
				lr_q  <= lr_next;
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0 && !log_sel_q) begin
					l1000_q   <= lr_next;
					log_sel_q <= 1'b1;
				end
			end
			aro_pkg::ST_TL_CMP: begin
				take_q <= {delta_w[31:0], 32'h0} < mul_prod;
			end
			aro_pkg::ST_APPLY: begin
				acc_flag_q <= take_q;
				rst_flag_q <= !take_q && restart;
			end
			default: begin
			end
		endcase

		if (state_q == aro_pkg::ST_FINISH && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {3'b000, run_q, aro_pkg::CITY_OUT_W'(city_q),
				aro_pkg::COST_OUT_W'(best_total_q), aro_pkg::COST_OUT_W'(cur_total_q),
				rst_flag_q, acc_flag_q, status_q};
		end
	end

	// ----------------------------------------------------------- assertions
	a_acc_rst_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
		else $error("accepted and restarted in one result");

	a_bad_move_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (!m_tdata[1] && !m_tdata[2]))
		else $error("invalid move reported a state change");

	a_dist_wr_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		dist_we |-> (state_q == aro_pkg::ST_DISPATCH))
		else $error("distance write outside dispatch");

	a_idle_no_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aro_pkg::ST_IDLE) |-> (!sweep_busy && !stat_s1.valid))
		else $error("slot walk running while idle");

	a_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_cmd.go |=> sweep_busy)
		else $error("slot walk did not start");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the annealing route optimizer. A distance table over
// a small set of cities and a full route are loaded after the first three
// directed items; the rest and about 1800 random items follow. Configuration
// changes between phases, and both stream sides stall at random. Each result
// is checked field by field against a typed value or the in-bench predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	localparam int NCITY       = 64;
	localparam int TOUR_CITIES = 8;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int RANDOM_ITEMS = 1800;

	// last field in the lowest bits
	typedef struct packed {
		logic [aro_pkg::DRAW_W-1:0]    draw;
		logic [aro_pkg::LOAD_W-1:0]    val;
		logic [aro_pkg::INDEX_B_W-1:0] b;
		logic [aro_pkg::INDEX_A_W-1:0] a;
		aro_pkg::op_t                  op;
	} cmd_t;

	typedef struct packed {
		logic [aro_pkg::STALL_W-1:0]    stall;
		logic [aro_pkg::CITY_OUT_W-1:0] city;
		logic [aro_pkg::COST_OUT_W-1:0] best;
		logic [aro_pkg::COST_OUT_W-1:0] cur;
		logic                           rst;
		logic                           acc;
		logic                           status;
	} res_t;

	typedef struct {
		cmd_t c;
		bit   typed;
		res_t r;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [aro_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [aro_pkg::OUT_DATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [aro_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [aro_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	annealing_route_optimizer_top dut (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data
	);

	// predictor state
	logic [15:0] dist_mem [NCITY*NCITY];
	logic [5:0]  cur_route [NCITY+1];
	logic [5:0]  best_route [NCITY+1];
	longint unsigned cur_total, best_total;
	logic [31:0] temp_now;
	logic [15:0] reject_run;
	int unsigned count_reg = 48;
	logic [31:0] start_temp = 262144000;
	logic [15:0] cool_reg = 64881;
	logic [15:0] stall_reg = 500;

	res_t pending_results [$];
	int fails = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int unsigned tour_size();
		if (count_reg < 3) return 3;
		if (count_reg > NCITY) return NCITY;
		return count_reg;
	endfunction

	function automatic longint unsigned route_cost(input logic [5:0] r [NCITY+1]);
		longint unsigned sum = 0;
		for (int i = 0; i < tour_size(); i++)
			sum += dist_mem[r[i]*NCITY + r[i+1]];
		return sum;
	endfunction

	function automatic longint unsigned log2_q16(input int unsigned v);
		int unsigned ip = 0;
		longint unsigned y;
		longint unsigned acc = 0;
		while ((v >> ip) > 1) ip++;
		y = longint'(v) << (30 - ip);
		acc = longint'(ip) << 16;
		for (int bt = 15; bt >= 0; bt--) begin
			y = (y * y) >> 30;
			if (y >= (64'd2 << 30)) begin
				y = y >> 1;
				acc |= 64'd1 << bt;
			end
		end
		return acc;
	endfunction

	function automatic bit metropolis_ok(input longint unsigned cand, input int unsigned draw);
		longint unsigned d, ln_q;
		if (cand < cur_total) return 1;
		if (draw == 0) return 1;
		if (draw >= aro_pkg::DRAW_SCALE) return 0;
		d = cand - cur_total;
		if (d >= (64'd1 << aro_pkg::DELTA_BITS)) return 0;
		ln_q = ((log2_q16(aro_pkg::DRAW_SCALE) - log2_q16(draw)) * aro_pkg::LN2_Q16) >> 16;
		return (d << 32) < longint'(temp_now) * ln_q;
	endfunction

	function automatic res_t anneal_step(input cmd_t c);
		res_t r = '0;
		logic [5:0] cand [NCITY+1];
		logic [5:0] t;
		int unsigned a, b, n, lo, hi;
		longint unsigned cc;
		a = c.a;
		b = c.b;
		n = tour_size();
		case (c.op)
			aro_pkg::OP_LOAD_DIST: if (a < NCITY && b < NCITY) dist_mem[a*NCITY + b] = c.val;
			aro_pkg::OP_LOAD_ROUTE: if (a <= NCITY) cur_route[a] = c.val[5:0];
			aro_pkg::OP_REVERSE, aro_pkg::OP_SWAP, aro_pkg::OP_INSERT: begin
				if (a == b || a < 1 || b < 1 || a > n - 1 || b > n - 1) begin
					r.status = 1'b1;
				end else begin
					cand = cur_route;
					if (c.op == aro_pkg::OP_REVERSE) begin
						lo = a < b ? a : b;
						hi = a < b ? b : a;
						while (lo < hi) begin
							t = cand[lo]; cand[lo] = cand[hi]; cand[hi] = t;
							lo++; hi--;
						end
					end else if (c.op == aro_pkg::OP_SWAP) begin
						t = cand[a]; cand[a] = cand[b]; cand[b] = t;
					end else begin
						t = cand[a];
						if (a < b) for (int i = a; i < b; i++) cand[i] = cand[i+1];
						else for (int i = a; i > b; i--) cand[i] = cand[i-1];
						cand[b] = t;
					end
					cc = route_cost(cand);
					if (metropolis_ok(cc, c.draw)) begin
						r.acc = 1'b1;
						reject_run = 0;
						cur_route = cand;
						cur_total = cc;
						if (cur_total < best_total) begin
							best_route = cur_route;
							best_total = cur_total;
						end
					end else begin
						reject_run = reject_run + 1'b1;
						if (reject_run >= (stall_reg == 0 ? 16'd1 : stall_reg)) begin
							r.rst = 1'b1;
							reject_run = 0;
							cur_route = best_route;
							cur_total = best_total;
						end
					end
					temp_now = 32'((longint'(temp_now) * cool_reg) >> 16);
				end
			end
			aro_pkg::OP_READ_BEST: if (a <= NCITY) r.city = best_route[a];
			aro_pkg::OP_START: begin
				cur_total = route_cost(cur_route);
				best_route = cur_route;
				best_total = cur_total;
				temp_now = start_temp;
				reject_run = 0;
			end
			default: ;
		endcase
		r.cur = cur_total[21:0];
		r.best = best_total[21:0];
		r.stall = reject_run;
		return r;
	endfunction

	task automatic send(input cmd_t c, input bit typed = 0, input res_t want = '0);
		res_t p;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= aro_pkg::IN_DATA_W'(c);
		do @(posedge clk); while (!s_tready);
		p = anneal_step(c);
		pending_results.push_back(typed ? want : p);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input aro_pkg::cfg_idx_t idx, input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			aro_pkg::CFG_CITY_COUNT:  count_reg = 32'(v[6:0]);
			aro_pkg::CFG_START_TEMP:  start_temp = v;
			aro_pkg::CFG_COOLING:     cool_reg = v[15:0];
			aro_pkg::CFG_STALL_LIMIT: stall_reg = v[15:0];
			default: ;
		endcase
	endtask

	function automatic cmd_t mk(input aro_pkg::op_t op, input int a, input int b, input int v,
			input int d);
		cmd_t c;
		c.op = op;
		c.a = aro_pkg::INDEX_A_W'(a);
		c.b = aro_pkg::INDEX_B_W'(b);
		c.val = aro_pkg::LOAD_W'(v);
		c.draw = aro_pkg::DRAW_W'(d);
		return c;
	endfunction

	function automatic int rand_dist();
		case ($urandom_range(5))
			0: return 0;
			1: return 16'hFFFF;
			2: return $urandom_range(65535);
			default: return $urandom_range(200);
		endcase
	endfunction

	function automatic int rand_city_val();
		return $urandom_range(TOUR_CITIES-1) + NCITY * $urandom_range(1023);
	endfunction

	// full table over the tour cities and every route slot, then start
	task automatic load_tour();
		for (int i = 0; i < TOUR_CITIES; i++)
			for (int j = 0; j < TOUR_CITIES; j++)
				send(mk(aro_pkg::OP_LOAD_DIST, i, j,
					(i == 0 && j == 1) ? 16'hFFFF : rand_dist(), 0));
		for (int s = 0; s <= NCITY; s++)
			send(mk(aro_pkg::OP_LOAD_ROUTE, s, 0, rand_city_val(), 0));
		send(mk(aro_pkg::OP_START, 0, 0, 0, 0));
	endtask

	function automatic cmd_t rand_cmd();
		int unsigned n = tour_size();
		int k = $urandom_range(99);
		int d;
		int a, b;
		case ($urandom_range(9))
			0: d = 0;
			1: d = $urandom_range(1023, 1000);
			default: d = $urandom_range(999);
		endcase
		if (k < 70) begin
			if ($urandom_range(9) == 0) begin
				a = $urandom_range(127);
				b = $urandom_range(63);
			end else begin
				a = $urandom_range(n-1, 1);
				b = $urandom_range(n-1, 1);
			end
			return mk(aro_pkg::op_t'($urandom_range(aro_pkg::OP_INSERT, aro_pkg::OP_REVERSE)),
				a, b, $urandom_range(65535), d);
		end
		if (k < 78) return mk(aro_pkg::OP_LOAD_DIST,
			$urandom_range(127) % ($urandom_range(1) ? 128 : TOUR_CITIES),
			$urandom_range(63) % ($urandom_range(1) ? 64 : TOUR_CITIES), rand_dist(), d);
		if (k < 83) return mk(aro_pkg::OP_LOAD_ROUTE, $urandom_range(127), $urandom_range(63),
			rand_city_val(), d);
		if (k < 90) return mk(aro_pkg::OP_READ_BEST, $urandom_range(127), $urandom_range(63),
			$urandom_range(65535), d);
		if (k < 96) return mk(aro_pkg::OP_START, $urandom_range(127), $urandom_range(63),
			$urandom_range(65535), d);
		return mk(aro_pkg::OP_NOP, $urandom_range(127), $urandom_range(63),
			$urandom_range(65535), d);
	endfunction

	always @(posedge clk) begin
		res_t got, want;
		if (m_tvalid && m_tready) begin
			got = res_t'(m_tdata[$bits(res_t)-1:0]);
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected, actual %h", $time, got);
				fails++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.acc !== want.acc ||
					got.rst !== want.rst || got.cur !== want.cur ||
					got.best !== want.best || got.city !== want.city ||
					got.stall !== want.stall) begin
					$display("%0t: mismatch expected %h actual %h", $time, want, got);
					fails++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	int unsigned cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	row_t rows [$];
	int unsigned ph_count [6] = '{48, 3, 64, 0, 127, 20};
	logic [31:0] ph_temp [6] = '{262144000, 1, 32'hFFFFFFFF, 262144000, 32'h00100000,
		32'h01000000};
	int unsigned ph_cool [6] = '{64881, 0, 65535, 64881, 60000, 65000};
	int unsigned ph_stall [6] = '{500, 1, 65535, 0, 5, 40};

	initial begin
		for (int i = 0; i < NCITY*NCITY; i++) dist_mem[i] = '0;
		for (int i = 0; i <= NCITY; i++) begin
			cur_route[i] = '0;
			best_route[i] = '0;
		end
		cur_total = 0; best_total = 0; temp_now = 0; reject_run = 0;

		// typed rows before the tour exists: nothing after reset, invalid moves
		rows.push_back('{mk(aro_pkg::OP_NOP, 127, 63, 16'hFFFF, 1023), 1, '0});
		rows.push_back('{mk(aro_pkg::OP_SWAP, 5, 5, 0, 0), 1, res_t'(1)});
		rows.push_back('{mk(aro_pkg::OP_REVERSE, 0, 3, 0, 0), 1, res_t'(1)});
		rows.push_back('{mk(aro_pkg::OP_START, 0, 0, 0, 0), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_READ_BEST, 0, 0, 0, 0), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_READ_BEST, 64, 0, 0, 0), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_READ_BEST, 65, 0, 0, 0), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_READ_BEST, 127, 63, 16'hFFFF, 1023), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_LOAD_DIST, 64, 0, 16'hFFFF, 0), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_LOAD_DIST, 127, 63, 16'hFFFF, 0), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_LOAD_ROUTE, 65, 0, 3, 0), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_LOAD_ROUTE, 64, 0, 16'hFFC5, 0), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_REVERSE, 1, 47, 0, 0), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_SWAP, 47, 1, 0, 999), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_INSERT, 2, 40, 0, 500), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_INSERT, 40, 2, 0, 1), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_REVERSE, 48, 3, 0, 0), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_SWAP, 1, 63, 0, 0), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_SWAP, 3, 9, 0, 1000), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_REVERSE, 9, 3, 0, 1023), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_INSERT, 1, 2, 16'hAAAA, 10'h155), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_INSERT, 2, 1, 16'h5555, 10'h2AA), 0, '0});
		rows.push_back('{mk(aro_pkg::OP_START, 0, 0, 0, 0), 0, '0});

		send_idle_pct = 11;
		recv_idle_pct = 53;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (i == 3) load_tour();
			send(rows[i].c, rows[i].typed, rows[i].r);
		end

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_reg(aro_pkg::CFG_CITY_COUNT, ph_count[ph]);
			write_reg(aro_pkg::CFG_START_TEMP, ph_temp[ph]);
			write_reg(aro_pkg::CFG_COOLING, ph_cool[ph]);
			write_reg(aro_pkg::CFG_STALL_LIMIT, ph_stall[ph]);
			send(mk(aro_pkg::OP_START, 0, 0, 0, 0));
			for (int k = 0; k < RANDOM_ITEMS / 6; k++) begin
				int idx = ph * (RANDOM_ITEMS / 6) + k;
				if (idx == RANDOM_ITEMS / 3) begin
					send_idle_pct = 53;
					recv_idle_pct = 11;
				end else if (idx == 2 * RANDOM_ITEMS / 3) begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				send(rand_cmd());
			end
		end

		drain();
		repeat (300) @(posedge clk);
		if (fails == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
